// ===== hdl/bch_pkg.sv =====
// Shared constants, types and codes for the BCH(31,21) decoder.
package bch_pkg;

	localparam int CW_BITS   = 31;
	localparam int DATA_BITS = 21;
	localparam int PAR_BITS  = 10;
	localparam int GEN_BITS  = PAR_BITS + 1;
	localparam int IDX_BITS  = $clog2(CW_BITS);
	localparam int DEG_BITS  = $clog2(GEN_BITS);

	localparam logic [GEN_BITS-1:0] POLY_RESET = GEN_BITS'(1897);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [1:0] STAT_NONE = 2'd0;
	localparam logic [1:0] STAT_ONE  = 2'd1;
	localparam logic [1:0] STAT_TWO  = 2'd2;
	localparam logic [1:0] STAT_BAD  = 2'd3;

	typedef enum logic [1:0] {
		CLS_CLEAN,
		CLS_SEARCH,
		CLS_BAD
	} bch_cls_t;

	typedef struct packed {
		logic [CW_BITS-1:0][PAR_BITS-1:0] syn;
		logic [CW_BITS-1:0]               ok;
		logic                             poly_zero;
		logic                             done;
	} bch_tbl_t;

	typedef struct packed {
		logic [CW_BITS-1:0]  word;
		logic [PAR_BITS-1:0] syn;
		bch_cls_t            cls;
	} bch_ent_t;

endpackage

// ===== hdl/bch_if.sv =====
// Valid/ready channel interfaces for codeword and result words.
interface bch_cw_if;
	logic                         valid;
	logic                         ready;
	logic [bch_pkg::CW_BITS-1:0]  codeword;

	modport source (output valid, output codeword, input ready);
	modport sink   (input valid, input codeword, output ready);
endinterface

interface bch_res_if;
	logic                          valid;
	logic                          ready;
	logic [bch_pkg::DATA_BITS-1:0] data;
	logic [1:0]                    status;

	modport source (output valid, output data, output status, input ready);
	modport sink   (input valid, input data, input status, output ready);
endinterface

// ===== hdl/bch_syn_table.sv =====
// Generator register and sequencer that builds the single-bit syndrome table.
module bch_syn_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bch_pkg::GEN_BITS-1:0]   cfg_wdata,
	output bch_pkg::bch_tbl_t              tbl
);

	typedef enum logic {
		ST_FILL,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [bch_pkg::GEN_BITS-1:0]      poly_q;
	logic [bch_pkg::IDX_BITS-1:0]      idx_q;
	logic [bch_pkg::PAR_BITS-1:0]      cur_q;
	logic [bch_pkg::CW_BITS-1:0][bch_pkg::PAR_BITS-1:0] syn_q;

	logic [bch_pkg::DEG_BITS-1:0]      deg;
	logic [bch_pkg::GEN_BITS-1:0]      shifted;
	logic [bch_pkg::PAR_BITS-1:0]      nxt;
	logic [bch_pkg::PAR_BITS-1:0]      val;

	always_comb begin
		deg = '0;
		for (int b = 0; b < bch_pkg::GEN_BITS; b++) begin
			if (poly_q[b]) begin
				deg = bch_pkg::DEG_BITS'(b);
			end
		end
		shifted = {cur_q, 1'b0};
		if (shifted[deg]) begin
			shifted = shifted ^ poly_q;
		end
		nxt = shifted[bch_pkg::PAR_BITS-1:0];
		if (idx_q == '0) begin
			val = (poly_q == bch_pkg::GEN_BITS'(1)) ? '0 : bch_pkg::PAR_BITS'(1);
		end else begin
			val = nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			poly_q  <= bch_pkg::POLY_RESET;
			idx_q   <= '0;
		end else if (cfg_we) begin
			state_q <= ST_FILL;
			poly_q  <= cfg_wdata;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (idx_q == bch_pkg::IDX_BITS'(bch_pkg::CW_BITS - 1)) begin
						state_q <= ST_DONE;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_DONE: begin
					idx_q <= '0;
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL && !cfg_we) begin
			cur_q <= val;
			syn_q <= {val, syn_q[bch_pkg::CW_BITS-1:1]};
		end
	end

	always_comb begin
		tbl.syn       = syn_q;
		tbl.poly_zero = (poly_q == '0);
		tbl.done      = (state_q == ST_DONE);
		for (int b = 0; b < bch_pkg::CW_BITS; b++) begin
			tbl.ok[b] = (poly_q != '0) || (b < bch_pkg::PAR_BITS);
		end
	end

endmodule

// ===== hdl/bch_front.sv =====
// Front end: accept codewords, form the syndrome and classify each word.
module bch_front (
	input  bch_pkg::bch_tbl_t  tbl,
	bch_cw_if.sink             cw,
	input  logic               q_full,
	output logic               push,
	output bch_pkg::bch_ent_t  ent
);

	logic [bch_pkg::PAR_BITS-1:0] syn;
	logic                         big;

	always_comb begin
		syn = '0;
		for (int b = 0; b < bch_pkg::CW_BITS; b++) begin
			if (cw.codeword[b]) begin
				syn = syn ^ tbl.syn[b];
			end
		end
		big = tbl.poly_zero && (cw.codeword[bch_pkg::CW_BITS-1:bch_pkg::PAR_BITS] != '0);
		ent.word = cw.codeword;
		ent.syn  = syn;
		if (big) begin
			ent.cls = bch_pkg::CLS_BAD;
		end else if (syn == '0) begin
			ent.cls = bch_pkg::CLS_CLEAN;
		end else begin
			ent.cls = bch_pkg::CLS_SEARCH;
		end
	end

	assign cw.ready = tbl.done && !q_full;
	assign push     = cw.valid && cw.ready;

endmodule

// ===== hdl/bch_fifo.sv =====
// Short queue between the front and back ends.
module bch_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bch_pkg::bch_ent_t  ent_in,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output bch_pkg::bch_ent_t  ent_out
);

	bch_pkg::bch_ent_t           mem_q [bch_pkg::Q_DEPTH];
	logic [bch_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [bch_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [bch_pkg::Q_AW:0]      count_q;

	assign full    = (count_q == (bch_pkg::Q_AW+1)'(bch_pkg::Q_DEPTH));
	assign valid   = (count_q != '0);
	assign ent_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ent_in;
		end
	end

endmodule

// ===== hdl/bch_back.sv =====
// Back end: search error patterns, apply the correction and drive results.
module bch_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bch_pkg::bch_tbl_t  tbl,
	input  logic               q_valid,
	input  bch_pkg::bch_ent_t  q_ent,
	output logic               pop,
	bch_res_if.source          res
);

	logic                                             s1_valid_q;
	logic [bch_pkg::CW_BITS-1:0]                      word_s1;
	bch_pkg::bch_cls_t                                cls_s1;
	logic                                             one_hit_s1;
	logic [bch_pkg::IDX_BITS-1:0]                     one_idx_s1;
	logic [bch_pkg::CW_BITS-1:0]                      two_hit_s1;
	logic [bch_pkg::CW_BITS-1:0][bch_pkg::IDX_BITS-1:0] two_idx_s1;

	logic                                             valid_q;
	logic [bch_pkg::DATA_BITS-1:0]                    data_q;
	logic [1:0]                                       status_q;

	logic                                             one_hit;
	logic [bch_pkg::IDX_BITS-1:0]                     one_idx;
	logic [bch_pkg::CW_BITS-1:0]                      two_hit;
	logic [bch_pkg::CW_BITS-1:0][bch_pkg::IDX_BITS-1:0] two_idx;
	logic [bch_pkg::PAR_BITS-1:0]                     target;

	logic                                             pick_hit;
	logic [bch_pkg::IDX_BITS-1:0]                     pick_b1;
	logic [bch_pkg::CW_BITS-1:0]                      fixed;
	logic [bch_pkg::DATA_BITS-1:0]                    data_d;
	logic [1:0]                                       status_d;

	logic                                             s2_free;
	logic                                             s1_free;

	assign s2_free = !valid_q || res.ready;
	assign s1_free = !s1_valid_q || s2_free;
	assign pop     = q_valid && s1_free;

	always_comb begin
		one_hit = 1'b0;
		one_idx = '0;
		for (int b = 0; b < bch_pkg::CW_BITS; b++) begin
			if (tbl.ok[b] && tbl.syn[b] == q_ent.syn) begin
				one_hit = 1'b1;
				one_idx = bch_pkg::IDX_BITS'(b);
			end
		end
		for (int b1 = 0; b1 < bch_pkg::CW_BITS; b1++) begin
			target      = q_ent.syn ^ tbl.syn[b1];
			two_hit[b1] = 1'b0;
			two_idx[b1] = '0;
			for (int b2 = bch_pkg::CW_BITS - 1; b2 > b1; b2--) begin
				if (tbl.ok[b1] && tbl.ok[b2] && tbl.syn[b2] == target) begin
					two_hit[b1] = 1'b1;
					two_idx[b1] = bch_pkg::IDX_BITS'(b2);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_free) begin
			s1_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_s1    <= q_ent.word;
			cls_s1     <= q_ent.cls;
			one_hit_s1 <= one_hit;
			one_idx_s1 <= one_idx;
			two_hit_s1 <= two_hit;
			two_idx_s1 <= two_idx;
		end
	end

	always_comb begin
		pick_hit = 1'b0;
		pick_b1  = '0;
		for (int b1 = bch_pkg::CW_BITS - 1; b1 >= 0; b1--) begin
			if (two_hit_s1[b1]) begin
				pick_hit = 1'b1;
				pick_b1  = bch_pkg::IDX_BITS'(b1);
			end
		end
		fixed    = word_s1;
		status_d = bch_pkg::STAT_BAD;
		case (cls_s1)
			bch_pkg::CLS_CLEAN: begin
				status_d = bch_pkg::STAT_NONE;
			end
			bch_pkg::CLS_SEARCH: begin
				if (one_hit_s1) begin
					fixed[one_idx_s1] = ~fixed[one_idx_s1];
					status_d          = bch_pkg::STAT_ONE;
				end else if (pick_hit) begin
					fixed[pick_b1]             = ~fixed[pick_b1];
					fixed[two_idx_s1[pick_b1]] = ~fixed[two_idx_s1[pick_b1]];
					status_d                   = bch_pkg::STAT_TWO;
				end
			end
			default: begin
				status_d = bch_pkg::STAT_BAD;
			end
		endcase
		if (status_d == bch_pkg::STAT_BAD) begin
			data_d = '0;
		end else begin
			data_d = fixed[bch_pkg::CW_BITS-1:bch_pkg::PAR_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s2_free) begin
			valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_valid_q) begin
			data_q   <= data_d;
			status_q <= status_d;
		end
	end

	assign res.valid  = valid_q;
	assign res.data   = data_q;
	assign res.status = status_q;

endmodule

// ===== hdl/bch_31_21_decoder.sv =====
// Top level of the double-error-correcting BCH(31,21) decoder.
// Decodes one 31-bit codeword per cycle while results are taken and the queue has room;
// an accepted word passes through the queue, the search stage and the output register, and
// the queue keeps accepting while results stall, until it fills. The syndrome of every
// single-bit error is held in a 31-entry table that a sequencer builds from the generator
// polynomial, one entry a cycle; while it builds, after reset and after each generator
// write, cw.ready stays low. Write the generator only while no word is in flight.
module bch_31_21_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bch_pkg::GEN_BITS-1:0]   cfg_wdata,
	bch_cw_if.sink                         cw,
	bch_res_if.source                      res
);

	bch_pkg::bch_tbl_t  tbl;
	bch_pkg::bch_ent_t  push_ent;
	bch_pkg::bch_ent_t  pop_ent;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_valid;

	bch_syn_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tbl       (tbl)
	);

	bch_front u_front (
		.tbl    (tbl),
		.cw     (cw),
		.q_full (q_full),
		.push   (push),
		.ent    (push_ent)
	);

	bch_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.ent_in  (push_ent),
		.full    (q_full),
		.pop     (pop),
		.valid   (q_valid),
		.ent_out (pop_ent)
	);

	bch_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tbl     (tbl),
		.q_valid (q_valid),
		.q_ent   (pop_ent),
		.pop     (pop),
		.res     (res)
	);

endmodule

// ===== verif/bch_31_21_decoder_test.sv =====
// Self-checking testbench for the BCH(31,21) decoder: directed table, then random codewords.
module bch_31_21_decoder_test;
	import bch_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SYN_SPAN    = 1 << PAR_BITS;
	localparam int GAP_MAX     = 18;
	localparam int RX_HOLD     = 150;
	localparam int HOLD_AT     = 250;
	localparam int SETTLE      = 8;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 116;
	localparam int DRAIN_LIMIT = 5000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_MAX    = 10;

	typedef enum logic {ROW_WORD, ROW_POLY} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CW_BITS-1:0]  value;
		bit                  known;
		logic [DATA_BITS-1:0] data;
		logic [1:0]          status;
	} stim_row_t;

	typedef struct {
		logic [DATA_BITS-1:0] data;
		logic [1:0]           status;
	} decoded_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [GEN_BITS-1:0] cfg_wdata;

	bch_cw_if  cw_ch ();
	bch_res_if res_ch ();

	bch_31_21_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cw        (cw_ch),
		.res       (res_ch)
	);

	logic [GEN_BITS-1:0]  gen_poly;
	logic [CW_BITS-1:0]   bit_syn [CW_BITS];
	decoded_t             decoded_q [$];
	int                   bad_words;
	int                   words_sent;
	int                   cycle_count;
	int                   tx_odds;
	int                   rx_odds;

	stim_row_t dir_rows [$] = '{
		'{ROW_WORD, 31'h0000_0000, 1'b1, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h7FFF_FFFF, 1'b1, 21'h1F_FFFF, STAT_NONE},
		'{ROW_WORD, 31'h0000_0001, 1'b1, 21'h00_0000, STAT_ONE},
		'{ROW_WORD, 31'h4000_0000, 1'b1, 21'h00_0000, STAT_ONE},
		'{ROW_WORD, 31'h0000_0400, 1'b1, 21'h00_0000, STAT_ONE},
		'{ROW_WORD, 31'h7FFF_FFFE, 1'b1, 21'h1F_FFFF, STAT_ONE},
		'{ROW_WORD, 31'h0000_0003, 1'b1, 21'h00_0000, STAT_TWO},
		'{ROW_WORD, 31'h6000_0000, 1'b1, 21'h00_0000, STAT_TWO},
		'{ROW_WORD, 31'h5555_5555, 1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h2AAA_AAAA, 1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h0000_0007, 1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_POLY, 31'd1024,      1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h0000_0003, 1'b1, 21'h00_0000, STAT_TWO},
		'{ROW_WORD, 31'h7FFF_FC00, 1'b1, 21'h1F_FFFF, STAT_NONE},
		'{ROW_WORD, 31'h0000_0007, 1'b1, 21'h00_0000, STAT_BAD},
		'{ROW_POLY, 31'd2047,      1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h1234_5678, 1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_POLY, 31'd0,         1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h0000_0000, 1'b1, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h0000_0400, 1'b1, 21'h00_0000, STAT_BAD},
		'{ROW_WORD, 31'h0000_0300, 1'b1, 21'h00_0000, STAT_TWO},
		'{ROW_WORD, 31'h0000_0200, 1'b1, 21'h00_0000, STAT_ONE},
		'{ROW_WORD, 31'h0000_03FF, 1'b1, 21'h00_0000, STAT_BAD},
		'{ROW_POLY, 31'd3,         1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h0000_0001, 1'b1, 21'h10_0000, STAT_ONE},
		'{ROW_WORD, 31'h0000_0003, 1'b1, 21'h00_0000, STAT_NONE},
		'{ROW_POLY, 31'd181,       1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h7654_3210, 1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_POLY, 31'd1,         1'b0, 21'h00_0000, STAT_NONE},
		'{ROW_WORD, 31'h7FFF_FFFF, 1'b1, 21'h1F_FFFF, STAT_NONE}
	};

	function automatic logic [CW_BITS-1:0] poly_mod(logic [GEN_BITS-1:0] g,
			logic [CW_BITS-1:0] w);
		logic [CW_BITS+GEN_BITS-1:0] acc;
		int deg;
		int b;
		int i;
		if (g == '0) begin
			return w;
		end
		deg = 0;
		for (b = 0; b < GEN_BITS; b++) begin
			if (g[b]) begin
				deg = b;
			end
		end
		acc = {{GEN_BITS{1'b0}}, w};
		for (i = CW_BITS - 1; i >= deg; i--) begin
			if (acc[i]) begin
				acc ^= (CW_BITS+GEN_BITS)'(g) << (i - deg);
			end
		end
		return acc[CW_BITS-1:0];
	endfunction

	task automatic load_poly(input logic [GEN_BITS-1:0] g);
		int b;
		gen_poly = g;
		for (b = 0; b < CW_BITS; b++) begin
			bit_syn[b] = poly_mod(g, CW_BITS'(1) << b);
		end
	endtask

	function automatic decoded_t decode_word(logic [CW_BITS-1:0] w);
		logic [CW_BITS-1:0] syn;
		logic [CW_BITS-1:0] flip;
		logic [CW_BITS-1:0] fixed;
		int b1;
		int b2;
		int hits;
		decoded_t r;
		syn = poly_mod(gen_poly, w);
		flip = '0;
		hits = 0;
		if (syn != '0 && syn < SYN_SPAN) begin
			for (b1 = 0; b1 < CW_BITS; b1++) begin
				if (bit_syn[b1] == syn) begin
					flip = CW_BITS'(1) << b1;
					hits = 1;
				end
			end
			for (b1 = 0; b1 < CW_BITS && hits == 0; b1++) begin
				for (b2 = b1 + 1; b2 < CW_BITS && hits == 0; b2++) begin
					if ((bit_syn[b1] ^ bit_syn[b2]) == syn) begin
						flip = (CW_BITS'(1) << b1) | (CW_BITS'(1) << b2);
						hits = 2;
					end
				end
			end
		end
		fixed = w ^ flip;
		if (syn == '0) begin
			r.data = w[CW_BITS-1:PAR_BITS];
			r.status = STAT_NONE;
		end else if (hits == 0) begin
			r.data = '0;
			r.status = STAT_BAD;
		end else begin
			r.data = fixed[CW_BITS-1:PAR_BITS];
			r.status = (hits == 1) ? STAT_ONE : STAT_TWO;
		end
		return r;
	endfunction

	function automatic logic [CW_BITS-1:0] noisy_word();
		logic [CW_BITS-1:0] w;
		int sel;
		int n;
		int k;
		w = {DATA_BITS'($urandom), {PAR_BITS{1'b0}}};
		w ^= poly_mod(gen_poly, w);
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			n = 0;
		end else if (sel < 45) begin
			n = 1;
		end else if (sel < 75) begin
			n = 2;
		end else if (sel < 88) begin
			n = 3;
		end else begin
			return CW_BITS'($urandom);
		end
		for (k = 0; k < n; k++) begin
			w[IDX_BITS'($urandom_range(0, CW_BITS - 1))] ^= 1'b1;
		end
		return w;
	endfunction

	task automatic send_word(input logic [CW_BITS-1:0] w, input decoded_t want);
		cw_ch.valid <= 1'b1;
		cw_ch.codeword <= w;
		do @(posedge clk); while (!cw_ch.ready);
		decoded_q.push_back(want);
		words_sent++;
	endtask

	task automatic write_poly(input logic [GEN_BITS-1:0] g);
		cw_ch.valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_poly(g);
	endtask

	task automatic tx_gap();
		if (tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
			cw_ch.valid <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
		end
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0: begin
				return 0;
			end
			1: begin
				return 2;
			end
			default: begin
				return 6;
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("bch_31_21_decoder verification failed");
			$finish;
		end
	end

	initial begin
		bit held;
		held = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && words_sent >= HOLD_AT) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end else if (rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (decoded_q.size() == 0) begin
				if (bad_words < SHOW_MAX) begin
					$display("unexpected word: data=%h status=%0d", res_ch.data,
						res_ch.status);
				end
				bad_words++;
			end else begin
				want = decoded_q.pop_front();
				if (res_ch.data !== want.data || res_ch.status !== want.status) begin
					if (bad_words < SHOW_MAX) begin
						$display("mismatch: expected data=%h status=%0d, got data=%h status=%0d",
							want.data, want.status, res_ch.data, res_ch.status);
					end
					bad_words++;
				end
			end
		end
	end

	initial begin
		logic [CW_BITS-1:0] w;
		logic [GEN_BITS-1:0] g;
		int ph;
		int n;
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cw_ch.valid = 1'b0;
		cw_ch.codeword = '0;
		bad_words = 0;
		words_sent = 0;
		cycle_count = 0;
		tx_odds = 0;
		rx_odds = 3;
		load_poly(POLY_RESET);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_POLY) begin
				write_poly(dir_rows[r].value[GEN_BITS-1:0]);
			end else if (dir_rows[r].known) begin
				send_word(dir_rows[r].value,
					decoded_t'{data: dir_rows[r].data, status: dir_rows[r].status});
			end else begin
				send_word(dir_rows[r].value, decode_word(dir_rows[r].value));
			end
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0, N_PHASES - 1: begin
					g = POLY_RESET;
				end
				2: begin
					g = {GEN_BITS{1'b1}};
				end
				3: begin
					g = GEN_BITS'($urandom_range(0, SYN_SPAN - 1));
				end
				4: begin
					g = GEN_BITS'(SYN_SPAN);
				end
				6: begin
					g = GEN_BITS'($urandom_range(0, 2 * SYN_SPAN - 1));
				end
				default: begin
					g = GEN_BITS'($urandom_range(SYN_SPAN, 2 * SYN_SPAN - 1));
				end
			endcase
			write_poly(g);
			if (ph == N_PHASES - 1) begin
				tx_odds = 0;
				rx_odds = 0;
			end else begin
				tx_odds = pick_odds();
				rx_odds = pick_odds();
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				tx_gap();
				w = noisy_word();
				send_word(w, decode_word(w));
			end
		end

		cw_ch.valid <= 1'b0;
		for (n = 0; n < DRAIN_LIMIT && decoded_q.size() != 0; n++) begin
			@(posedge clk);
		end
		bad_words += decoded_q.size();
		repeat (SETTLE) @(posedge clk);
		if (bad_words == 0) begin
			$display("bch_31_21_decoder verification clean");
		end else begin
			$display("bch_31_21_decoder verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bch_pkg.sv
hdl/bch_if.sv
hdl/bch_syn_table.sv
hdl/bch_front.sv
hdl/bch_fifo.sv
hdl/bch_back.sv
hdl/bch_31_21_decoder.sv
verif/bch_31_21_decoder_test.sv
